/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros
// concurrent checks that compile away when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property must hold at every clock edge outside reset
`define ASSERT_PROP(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// condition must never be seen at a clock edge outside reset
`define ASSERT_NEVER(name, clk, rst_n, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(name, clk, rst_n, prop, msg)
`define ASSERT_NEVER(name, clk, rst_n, cond, msg)

`endif

`endif

/* sv/kmp_pkg.sv */
// ----------------------------------------------------------------------------
// kmp_pkg
// shared constants, codes and types of the kmp stream matcher
// ----------------------------------------------------------------------------
package kmp_pkg;

    localparam int MAX_PATTERN   = 64;
    localparam int POSITION_BITS = 32;

    localparam int SYM_W   = 16;
    localparam int START_W = 32;
    localparam int MODE_W  = 2;
    localparam int STAT_W  = 2;

    // lengths run from 0 to MAX_PATTERN inclusive
    localparam int LEN_W   = $clog2(MAX_PATTERN + 1);
    localparam int PAT_AW  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    localparam int IN_TDATA_W  = ((SYM_W + 7) / 8) * 8;
    localparam int IN_TUSER_W  = MODE_W + 1;
    localparam int OUT_TDATA_W = ((1 + START_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - 1 - START_W;

    localparam logic [MODE_W-1:0] MODE_LOAD    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TEXT    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RESTART = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK         = 2'd0;
    localparam logic [STAT_W-1:0] ST_TOO_LONG   = 2'd1;
    localparam logic [STAT_W-1:0] ST_NO_PATTERN = 2'd2;

    typedef struct packed {
        logic [LEN_W-1:0]  rd_addr;
        logic              pat_we;
        logic [PAT_AW-1:0] pat_waddr;
        logic [SYM_W-1:0]  pat_wdata;
        logic              fail_we;
        logic [LEN_W-1:0]  fail_waddr;
        logic [LEN_W-1:0]  fail_wdata;
    } tbl_req_t;

    typedef struct packed {
        logic               found;
        logic [START_W-1:0] start;
        logic [STAT_W-1:0]  status;
    } res_t;

endpackage

/* sv/kmp_tables.sv */
// ----------------------------------------------------------------------------
// kmp_tables
// pattern store and failure table, one write and one registered read each
// ----------------------------------------------------------------------------
module kmp_tables (
    input  logic                                aclk,
    input  kmp_pkg::tbl_req_t                   req,
    output logic [kmp_pkg::SYM_W-1:0]           pat_rd,
    output logic [kmp_pkg::LEN_W-1:0]           fail_rd
);
    import kmp_pkg::*;

    logic [SYM_W-1:0] pat_mem  [MAX_PATTERN];
    logic [LEN_W-1:0] fail_mem [MAX_PATTERN + 1];

    always_ff @(posedge aclk) begin
        if (req.pat_we) begin
            pat_mem[req.pat_waddr] <= req.pat_wdata;
        end
        // address equal to MAX_PATTERN wraps here, its data is never used
        pat_rd <= pat_mem[req.rd_addr[PAT_AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (req.fail_we) begin
            fail_mem[req.fail_waddr] <= req.fail_wdata;
        end
        fail_rd <= fail_mem[req.rd_addr];
    end

endmodule

/* sv/kmp_engine.sv */
// ----------------------------------------------------------------------------
// kmp_engine
// sequencer around one symbol compare that walks the failure chain
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module kmp_engine (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [kmp_pkg::MODE_W-1:0]      in_mode,
    input  logic                            in_first,
    input  logic [kmp_pkg::SYM_W-1:0]       in_symbol,
    output kmp_pkg::tbl_req_t               tbl_req,
    input  logic [kmp_pkg::SYM_W-1:0]       pat_rd,
    input  logic [kmp_pkg::LEN_W-1:0]       fail_rd,
    input  logic                            out_free,
    output logic                            res_valid,
    output kmp_pkg::res_t                   res
);
    import kmp_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIX,
        S_CMP,
        S_FALL,
        S_FIN
    } state_t;

    state_t                   state_reg, state_next;
    logic                     load_reg, load_next;
    logic [SYM_W-1:0]         sym_reg, sym_next;
    logic [LEN_W-1:0]         k_reg, k_next;
    logic [LEN_W-1:0]         len_reg, len_next;
    logic [LEN_W-1:0]         bp_reg, bp_next;
    logic [LEN_W-1:0]         matched_reg, matched_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [STAT_W-1:0]        stat_reg, stat_next;

    logic                     eq;
    logic                     step_back;
    logic [LEN_W-1:0]         k_inc;
    logic [LEN_W-1:0]         load_idx;
    logic [POSITION_BITS-1:0] start_pos;

    // the shared compare: one pattern unit against the held symbol
    assign eq        = (pat_rd == sym_reg);
    assign step_back = (k_reg != '0) && !eq;
    assign k_inc     = k_reg + LEN_W'(eq);
    assign load_idx  = in_first ? '0 : len_reg;
    assign start_pos = pos_reg - POSITION_BITS'(len_reg) + POSITION_BITS'(1);

    assign in_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next   = state_reg;
        load_next    = load_reg;
        sym_next     = sym_reg;
        k_next       = k_reg;
        len_next     = len_reg;
        bp_next      = bp_reg;
        matched_next = matched_reg;
        pos_next     = pos_reg;
        stat_next    = stat_reg;

        tbl_req            = '0;
        tbl_req.rd_addr    = k_reg;
        tbl_req.pat_wdata  = in_symbol;
        tbl_req.pat_waddr  = load_idx[PAT_AW-1:0];
        tbl_req.fail_waddr = len_reg + LEN_W'(1);
        tbl_req.fail_wdata = k_inc;

        res_valid = 1'b0;
        res       = '0;

        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    sym_next  = in_symbol;
                    stat_next = ST_OK;
                    state_next = S_FIN;
                    case (in_mode)
                        MODE_LOAD: begin
                            load_next = 1'b1;
                            if (in_first) begin
                                len_next     = '0;
                                bp_next      = '0;
                                matched_next = '0;
                            end
                            if (load_idx >= LEN_W'(MAX_PATTERN)) begin
                                stat_next = ST_TOO_LONG;
                            end else begin
                                tbl_req.pat_we = 1'b1;
                                if (load_idx == '0) begin
                                    tbl_req.fail_we    = 1'b1;
                                    tbl_req.fail_waddr = LEN_W'(1);
                                    tbl_req.fail_wdata = '0;
                                    bp_next            = '0;
                                    len_next           = LEN_W'(1);
                                end else begin
                                    k_next          = bp_reg;
                                    tbl_req.rd_addr = bp_reg;
                                    state_next      = S_CMP;
                                end
                            end
                        end
                        MODE_TEXT: begin
                            load_next = 1'b0;
                            if (len_reg == '0) begin
                                stat_next = ST_NO_PATTERN;
                                pos_next  = pos_reg + POSITION_BITS'(1);
                            end else if (matched_reg >= len_reg) begin
                                tbl_req.rd_addr = len_reg;
                                state_next      = S_FIX;
                            end else begin
                                k_next          = matched_reg;
                                tbl_req.rd_addr = matched_reg;
                                state_next      = S_CMP;
                            end
                        end
                        MODE_RESTART: begin
                            pos_next     = '0;
                            matched_next = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_FIX: begin
                k_next          = fail_rd;
                tbl_req.rd_addr = fail_rd;
                state_next      = S_CMP;
            end
            S_CMP: begin
                if (step_back) begin
                    k_next          = fail_rd;
                    tbl_req.rd_addr = fail_rd;
                end else if (load_reg) begin
                    if (out_free) begin
                        tbl_req.fail_we = 1'b1;
                        bp_next         = k_inc;
                        len_next        = len_reg + LEN_W'(1);
                        res_valid       = 1'b1;
                        state_next      = S_IDLE;
                    end
                end else if (k_inc == len_reg) begin
                    // full match: fetch the border to fall back to
                    k_next          = k_inc;
                    tbl_req.rd_addr = k_inc;
                    state_next      = S_FALL;
                end else if (out_free) begin
                    matched_next = k_inc;
                    pos_next     = pos_reg + POSITION_BITS'(1);
                    res_valid    = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_FALL: begin
                if (out_free) begin
                    matched_next = fail_rd;
                    pos_next     = pos_reg + POSITION_BITS'(1);
                    res_valid    = 1'b1;
                    res.found    = 1'b1;
                    res.start    = START_W'(start_pos);
                    state_next   = S_IDLE;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    res_valid  = 1'b1;
                    res.status = stat_reg;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            len_reg     <= '0;
            bp_reg      <= '0;
            matched_reg <= '0;
            pos_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            len_reg     <= len_next;
            bp_reg      <= bp_next;
            matched_reg <= matched_next;
            pos_reg     <= pos_next;
        end
        load_reg <= load_next;
        sym_reg  <= sym_next;
        k_reg    <= k_next;
        stat_reg <= stat_next;
    end

    `ASSERT_NEVER(a_k_below_len, aclk, aresetn, (state_reg == S_CMP) && (k_reg >= len_reg), "match length walked past pattern length")
    `ASSERT_NEVER(a_border_proper, aclk, aresetn, (len_reg != '0) && (bp_reg >= len_reg), "pattern border not proper")
    `ASSERT_NEVER(a_matched_range, aclk, aresetn, (len_reg != '0) && (matched_reg >= len_reg), "stored match length not below pattern length")
    `ASSERT_NEVER(a_no_lost_result, aclk, aresetn, res_valid && !out_free, "result issued into a full output register")
    `ASSERT_PROP(a_len_bounded, aclk, aresetn, len_reg <= LEN_W'(MAX_PATTERN), "pattern length beyond store")

endmodule

/* sv/kmp_stream_matcher.sv */
// ----------------------------------------------------------------------------
// kmp_stream_matcher
// knuth-morris-pratt matcher over 16-bit code units with a streamed pattern
// ----------------------------------------------------------------------------
// Every input transfer gives exactly one result transfer. A load transfer
// appends one pattern unit (first_unit starts a new pattern) and extends the
// failure table; a text transfer reports whether an occurrence ends there and
// its start position. Items are handled one at a time by a single compare
// that reads one pattern unit per cycle from the pattern store while not
// stalled, one per failure-chain step; a text item that completes a match
// also passes a fall-back state, and restart and rejected items a finish
// state. The next item is taken while the previous result still sits in
// the output register; the block stalls only when that register is still
// full at the end of an item.
module kmp_stream_matcher (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // symbol
    input  logic [kmp_pkg::IN_TDATA_W-1:0]      s_tdata,
    // mode [1:0], first_unit [2]
    input  logic [kmp_pkg::IN_TUSER_W-1:0]      s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // match_found [0], match_start [32:1], zero pad above
    output logic [kmp_pkg::OUT_TDATA_W-1:0]     m_tdata,
    // status
    output logic [kmp_pkg::STAT_W-1:0]          m_tuser
);
    import kmp_pkg::*;

    tbl_req_t         tbl_req;
    logic [SYM_W-1:0] pat_rd;
    logic [LEN_W-1:0] fail_rd;
    logic             out_free;
    logic             res_valid;
    res_t             res;

    logic             out_valid_reg, out_valid_next;
    res_t             out_reg, out_next;

    assign out_free = !out_valid_reg || m_tready;

    kmp_tables u_tables (
        .aclk    (aclk),
        .req     (tbl_req),
        .pat_rd  (pat_rd),
        .fail_rd (fail_rd)
    );

    kmp_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_mode   (s_tuser[MODE_W-1:0]),
        .in_first  (s_tuser[MODE_W]),
        .in_symbol (s_tdata[SYM_W-1:0]),
        .tbl_req   (tbl_req),
        .pat_rd    (pat_rd),
        .fail_rd   (fail_rd),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res       (res)
    );

    // output register parts the result side from the sequencer
    always_comb begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (res_valid) begin
            out_valid_next = 1'b1;
            out_next       = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
        out_reg <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{OUT_PAD_W{1'b0}}, out_reg.start, out_reg.found};
    assign m_tuser  = out_reg.status;

endmodule
